// ===== rtl/packed_yuv422_to_yuv420_converter_assert.svh =====
// Assertion macros shared by the converter modules.
// Each expects signals named clock and reset in the scope where it is used.
`ifndef PACKED_YUV422_TO_YUV420_CONVERTER_ASSERT_SVH
`define PACKED_YUV422_TO_YUV420_CONVERTER_ASSERT_SVH

// same-cycle implication
`define PYC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PYC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pyc_pkg.sv =====
// Shared types and constants of the packed 4:2:2 to 4:2:0 converter.
// No dependencies.
package pyc_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam int PAIR_W   = 13;
   localparam int CFG_W    = 12;
   localparam int LUMA_AW  = 24;
   localparam int CHROMA_AW = 25;
   localparam int IN_W     = 32;
   localparam int OUT_W    = 112;
   localparam int CSR_IW   = 2;

   localparam logic [CSR_IW-1:0] CSR_WIDTH_PAIRS   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_HEIGHT_PAIRS  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_INPUT_ORDER   = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_OUTPUT_LAYOUT = 2'd3;

   localparam logic ORDER_YUYV  = 1'b0;
   localparam logic ORDER_UYVY  = 1'b1;
   localparam logic LAYOUT_NV12 = 1'b0;
   localparam logic LAYOUT_I420 = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_PAIRS_RESET  = 12'd320;
   localparam logic [CFG_W-1:0] HEIGHT_PAIRS_RESET = 12'd240;

   typedef struct packed {
      logic [CFG_W-1:0] width_pairs;
      logic [CFG_W-1:0] height_pairs;
      logic             input_order;
      logic             output_layout;
   } cfg_type;

   typedef struct packed {
      logic [LUMA_AW-1:0]   luma_addr;
      logic [7:0]           y0;
      logic [7:0]           y1;
      logic [7:0]           u;
      logic [7:0]           v;
      logic                 chroma;
      logic                 fend;
      logic [PAIR_W-1:0]    col;
      logic [CHROMA_AW-1:0] row_base;
      logic [CHROMA_AW-1:0] area;
   } stage_type;

   typedef struct packed {
      logic we;
      logic re;
   } line_ctl_type;

endpackage

// ===== rtl/pyc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pyc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pyc_front.sv =====
// Input stage: frame position counters, line store control and address products.
// Depends on pyc_pkg and the assertion macro header.
`include "packed_yuv422_to_yuv420_converter_assert.svh"
module pyc_front #(
   parameter int MAX_WIDTH  = pyc_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = pyc_pkg::MAX_HEIGHT_DEFAULT,
   localparam int LINE_DEPTH = MAX_WIDTH / 2,
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
   localparam int ROW_W      = $clog2(MAX_HEIGHT)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pyc_pkg::cfg_type           cfg,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pyc_pkg::IN_W-1:0]   req_tdata,   // byte_zero, byte_one, byte_two, byte_three
   input  logic                       s1_ready,
   output logic                       s1_valid,
   output pyc_pkg::stage_type         s1,
   output pyc_pkg::line_ctl_type      line_ctl,
   output logic [LINE_AW-1:0]         line_addr,
   output logic [15:0]                line_wdata
);

   localparam logic [pyc_pkg::PAIR_W-1:0] W_LIMIT = pyc_pkg::PAIR_W'(MAX_WIDTH / 2);
   localparam logic [pyc_pkg::PAIR_W-1:0] H_LIMIT = pyc_pkg::PAIR_W'(MAX_HEIGHT / 2);

   logic [LINE_AW-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [pyc_pkg::LUMA_AW-1:0] luma_ff, luma_in;
   logic                        s1_valid_ff, s1_valid_in;
   pyc_pkg::stage_type          s1_ff, s1_in;

   logic [pyc_pkg::PAIR_W-1:0]  wp, hp, wp_raw, hp_raw, col_ext;
   logic [pyc_pkg::PAIR_W:0]    row_ext, rows;
   logic                        accept, last_col, last_row, fend;
   logic [7:0]                  b0, b1, b2, b3, y0, y1, u, v;
   logic [ROW_W-1:0]            pair_row;

   assign wp_raw = pyc_pkg::PAIR_W'(cfg.width_pairs);
   assign hp_raw = pyc_pkg::PAIR_W'(cfg.height_pairs);

   always_comb begin
      if (wp_raw == '0) begin
         wp = pyc_pkg::PAIR_W'(1);
      end else if (wp_raw > W_LIMIT) begin
         wp = W_LIMIT;
      end else begin
         wp = wp_raw;
      end
      if (hp_raw == '0) begin
         hp = pyc_pkg::PAIR_W'(1);
      end else if (hp_raw > H_LIMIT) begin
         hp = H_LIMIT;
      end else begin
         hp = hp_raw;
      end
   end

   assign req_tready = !s1_valid_ff || s1_ready;
   assign accept     = req_tvalid && req_tready;

   assign col_ext  = pyc_pkg::PAIR_W'(col_ff);
   assign row_ext  = (pyc_pkg::PAIR_W + 1)'(row_ff);
   assign rows     = {hp, 1'b0};
   assign last_col = (col_ext + pyc_pkg::PAIR_W'(1)) >= wp;
   assign last_row = (row_ext + (pyc_pkg::PAIR_W + 1)'(1)) >= rows;
   assign fend     = last_col && last_row;
   assign pair_row = row_ff >> 1;

   assign b0 = req_tdata[7:0];
   assign b1 = req_tdata[15:8];
   assign b2 = req_tdata[23:16];
   assign b3 = req_tdata[31:24];

   always_comb begin
      if (cfg.input_order == pyc_pkg::ORDER_UYVY) begin
         u = b0; y0 = b1; v = b2; y1 = b3;
      end else begin
         y0 = b0; u = b1; y1 = b2; v = b3;
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      luma_in = luma_ff;
      if (accept) begin
         if (fend) begin
            col_in  = '0;
            row_in  = '0;
            luma_in = '0;
         end else begin
            luma_in = luma_ff + pyc_pkg::LUMA_AW'(2);
            if (last_col) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + LINE_AW'(1);
            end
         end
      end
   end

   always_comb begin
      s1_in.luma_addr = luma_ff;
      s1_in.y0        = y0;
      s1_in.y1        = y1;
      s1_in.u         = u;
      s1_in.v         = v;
      s1_in.chroma    = row_ff[0];
      s1_in.fend      = fend;
      s1_in.col       = (col_ext < wp) ? col_ext : (wp - pyc_pkg::PAIR_W'(1));
      s1_in.row_base  = pyc_pkg::CHROMA_AW'(pair_row) * pyc_pkg::CHROMA_AW'(wp);
      s1_in.area      = pyc_pkg::CHROMA_AW'(wp) * pyc_pkg::CHROMA_AW'(hp);
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         luma_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         luma_ff     <= luma_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid    = s1_valid_ff;
   assign s1          = s1_ff;
   assign line_ctl.we = accept && !row_ff[0];
   assign line_ctl.re = accept && row_ff[0];
   assign line_addr   = col_ff;
   assign line_wdata  = {v, u};

   `PYC_ASSERT_NEXT(a_frame_wrap, accept && fend, (col_ff == '0) && (row_ff == '0) && (luma_ff == '0), "counters not cleared after frame end")
   `PYC_ASSERT_NEXT(a_stage_hold, s1_valid_ff && !s1_ready, s1_valid_ff && $stable(s1_ff), "stalled stage word lost")

endmodule

// ===== rtl/pyc_back.sv =====
// Output stage: chroma averaging, plane address arithmetic and result register.
// Depends on pyc_pkg and the assertion macro header.
`include "packed_yuv422_to_yuv420_converter_assert.svh"
module pyc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        output_layout,
   input  logic                        s1_valid,
   input  pyc_pkg::stage_type          s1,
   output logic                        s1_ready,
   input  logic [15:0]                 line_rdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [pyc_pkg::OUT_W-1:0]   rsp_tdata,  // luma_addr, luma_first, luma_second,
                                                   // u_addr, u_value, v_addr, v_value, zero pad
   output logic                        rsp_tuser,  // chroma_valid
   output logic                        rsp_tlast   // frame_end
);

   localparam int AW = pyc_pkg::CHROMA_AW;

   logic                out_valid_ff, out_valid_in;
   logic                take;
   logic [AW-1:0]       pos, ysize, ua, va, u_addr_ff, v_addr_ff;
   logic [8:0]          u_sum, v_sum;
   logic [7:0]          u_avg, v_avg, u_val_ff, v_val_ff, y0_ff, y1_ff;
   logic [pyc_pkg::LUMA_AW-1:0] luma_ff;
   logic                chroma_ff, fend_ff;

   assign s1_ready = !out_valid_ff || rsp_tready;
   assign take     = s1_valid && s1_ready;

   assign pos   = s1.row_base + AW'(s1.col);
   assign ysize = {s1.area[AW-3:0], 2'b00};
   assign u_sum = {1'b0, line_rdata[7:0]} + {1'b0, s1.u};
   assign v_sum = {1'b0, line_rdata[15:8]} + {1'b0, s1.v};
   assign u_avg = u_sum[8:1];
   assign v_avg = v_sum[8:1];

   always_comb begin
      if (output_layout == pyc_pkg::LAYOUT_I420) begin
         ua = ysize + pos;
         va = ua + s1.area;
      end else begin
         ua = ysize + {pos[AW-2:0], 1'b0};
         va = ua + AW'(1);
      end
   end

   assign out_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         luma_ff   <= s1.luma_addr;
         y0_ff     <= s1.y0;
         y1_ff     <= s1.y1;
         chroma_ff <= s1.chroma;
         fend_ff   <= s1.fend;
         u_addr_ff <= s1.chroma ? ua : '0;
         v_addr_ff <= s1.chroma ? va : '0;
         u_val_ff  <= s1.chroma ? u_avg : '0;
         v_val_ff  <= s1.chroma ? v_avg : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, v_val_ff, v_addr_ff, u_val_ff, u_addr_ff, y1_ff, y0_ff, luma_ff};
   assign rsp_tuser  = chroma_ff;
   assign rsp_tlast  = fend_ff;

   `PYC_ASSERT_NOW(a_luma_only_zero, out_valid_ff && !chroma_ff, (u_addr_ff == '0) && (v_addr_ff == '0) && (u_val_ff == '0) && (v_val_ff == '0), "chroma fields set on first row")
   `PYC_ASSERT_NOW(a_nv12_pair, out_valid_ff && chroma_ff && (output_layout == pyc_pkg::LAYOUT_NV12), v_addr_ff == (u_addr_ff + AW'(1)), "NV12 V not beside U")

endmodule

// ===== rtl/packed_yuv422_to_yuv420_converter.sv =====
// Packed YUYV/UYVY to NV12/I420 converter, one macropixel word per cycle while rsp_tready does not stall it.
// Each accepted word is registered in the front stage and then in the back stage result register.
// The line store is a single-port RAM, written on first rows, read on second rows.
// Reset (synchronous, active high) clears counters and pipeline valids and loads
// width 320 pairs, height 240 pairs, YUYV in, NV12 out. Line store is not cleared.
module packed_yuv422_to_yuv420_converter #(
   parameter int MAX_WIDTH  = pyc_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = pyc_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pyc_pkg::IN_W-1:0]      req_tdata,   // byte_zero, byte_one, byte_two, byte_three
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pyc_pkg::OUT_W-1:0]     rsp_tdata,   // luma_addr, luma_first, luma_second,
                                                      // u_addr, u_value, v_addr, v_value, zero pad
   output logic                          rsp_tuser,   // chroma_valid
   output logic                          rsp_tlast,   // frame_end
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pyc_pkg::CSR_IW-1:0]    csr_index,
   input  logic [pyc_pkg::CFG_W-1:0]     csr_data
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   pyc_pkg::cfg_type       cfg_ff, cfg_in;
   pyc_pkg::stage_type     s1;
   pyc_pkg::line_ctl_type  line_ctl;
   logic                   s1_valid, s1_ready;
   logic [LINE_AW-1:0]     line_addr;
   logic [15:0]            line_wdata, line_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pyc_pkg::CSR_WIDTH_PAIRS:   cfg_in.width_pairs   = csr_data;
            pyc_pkg::CSR_HEIGHT_PAIRS:  cfg_in.height_pairs  = csr_data;
            pyc_pkg::CSR_INPUT_ORDER:   cfg_in.input_order   = csr_data[0];
            pyc_pkg::CSR_OUTPUT_LAYOUT: cfg_in.output_layout = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_pairs   <= pyc_pkg::WIDTH_PAIRS_RESET;
         cfg_ff.height_pairs  <= pyc_pkg::HEIGHT_PAIRS_RESET;
         cfg_ff.input_order   <= pyc_pkg::ORDER_YUYV;
         cfg_ff.output_layout <= pyc_pkg::LAYOUT_NV12;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pyc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .s1_ready   (s1_ready),
      .s1_valid   (s1_valid),
      .s1         (s1),
      .line_ctl   (line_ctl),
      .line_addr  (line_addr),
      .line_wdata (line_wdata)
   );

   pyc_ram #(
      .WIDTH (16),
      .DEPTH (LINE_DEPTH),
      .AW    (LINE_AW)
   ) u_line (
      .clock (clock),
      .we    (line_ctl.we),
      .re    (line_ctl.re),
      .addr  (line_addr),
      .wdata (line_wdata),
      .rdata (line_rdata)
   );

   pyc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .output_layout (cfg_ff.output_layout),
      .s1_valid      (s1_valid),
      .s1            (s1),
      .s1_ready      (s1_ready),
      .line_rdata    (line_rdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule
